/* hdl/mpm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpm_pkg: shared constants for the 2x2 modular matrix power block
// Default field widths and the number of remainder bits retired per cycle.
// ----------------------------------------------------------------------------
package mpm_pkg;

    // Width of matrix entries and modulus
    localparam int MOD_BITS = 16;
    // Width of the exponent
    localparam int EXP_BITS = 31;
    // Dividend bits consumed per cycle by the remainder unit
    localparam int RED_STEP = 4;

endpackage

/* hdl/mpm_ifs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpm channel interfaces
// Valid/ready channels for the input matrix request and the result matrix.
// ----------------------------------------------------------------------------
interface mpm_in_if #(
    parameter int MOD_BITS = mpm_pkg::MOD_BITS,
    parameter int EXP_BITS = mpm_pkg::EXP_BITS
);
    logic                valid;
    logic                ready;
    logic [MOD_BITS-1:0] a00;
    logic [MOD_BITS-1:0] a01;
    logic [MOD_BITS-1:0] a10;
    logic [MOD_BITS-1:0] a11;
    logic [EXP_BITS-1:0] exponent;
    logic [MOD_BITS-1:0] modulus;

    modport source (output valid, a00, a01, a10, a11, exponent, modulus, input ready);
    modport sink   (input valid, a00, a01, a10, a11, exponent, modulus, output ready);
endinterface

interface mpm_out_if #(
    parameter int MOD_BITS = mpm_pkg::MOD_BITS
);
    logic                valid;
    logic                ready;
    logic [MOD_BITS-1:0] r00;
    logic [MOD_BITS-1:0] r01;
    logic [MOD_BITS-1:0] r10;
    logic [MOD_BITS-1:0] r11;

    modport source (output valid, r00, r01, r10, r11, input ready);
    modport sink   (input valid, r00, r01, r10, r11, output ready);
endinterface

/* hdl/matrix_power_mod_2x2.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_power_mod_2x2: 2x2 matrix power modulo m
// Left-to-right square-and-multiply over all exponent bits, every matrix
// entry computed on one shared multiply and reduce unit.
//
//   channel  dir  handshake            payload
//   i_req    in   valid/ready          a00 a01 a10 a11 exponent modulus
//   o_rsp    out  valid/ready          r00 r01 r10 r11
//
// Each matrix entry is one issue state plus one pass through the shared
// unit; a matrix product is four entries plus one update state.
// i_req.ready is high only while no item is in work.
// A result waits in the output register; a stalled o_rsp holds the block
// before it loads the next result.
// Reset clears control state only.
// ----------------------------------------------------------------------------
module matrix_power_mod_2x2 #(
    parameter int MOD_BITS = mpm_pkg::MOD_BITS,
    parameter int EXP_BITS = mpm_pkg::EXP_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mpm_in_if.sink      i_req,
    mpm_out_if.source   o_rsp
);
    import mpm_pkg::*;

    localparam int BIT_W = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;

    localparam logic [1:0] ENT_00 = 2'd0;
    localparam logic [1:0] ENT_01 = 2'd1;
    localparam logic [1:0] ENT_10 = 2'd2;
    localparam logic [1:0] ENT_11 = 2'd3;

    typedef struct packed {
        logic [MOD_BITS-1:0] e00;
        logic [MOD_BITS-1:0] e01;
        logic [MOD_BITS-1:0] e10;
        logic [MOD_BITS-1:0] e11;
    } t_mat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_STEP,
        ST_OUT
    } t_state;

    t_state              r_state;
    t_mat                r_acc;
    t_mat                r_base;
    t_mat                r_res;
    t_mat                r_out;
    logic [MOD_BITS:0]   r_mod;
    logic [EXP_BITS-1:0] r_exp;
    logic [BIT_W-1:0]    r_bit;
    logic                r_mul_base;
    logic [1:0]          r_ent;
    logic                r_out_valid;

    t_mat                rhs;
    logic [MOD_BITS-1:0] op_x0, op_y0, op_x1, op_y1;
    logic                mr_start;
    logic                mr_done;
    logic [MOD_BITS-1:0] mr_result;
    logic                in_xfer;
    logic                out_xfer;
    logic                out_load;

    assign in_xfer  = i_req.valid && i_req.ready;
    assign out_xfer = o_rsp.valid && o_rsp.ready;
    assign out_load = (r_state == ST_OUT) && (!r_out_valid || o_rsp.ready);
    assign mr_start = (r_state == ST_ISSUE);

    // Select operands for one entry of acc * rhs
    always_comb begin
        rhs = r_mul_base ? r_base : r_acc;
        unique case (r_ent)
            ENT_00: begin
                op_x0 = r_acc.e00; op_y0 = rhs.e00; op_x1 = r_acc.e01; op_y1 = rhs.e10;
            end
            ENT_01: begin
                op_x0 = r_acc.e00; op_y0 = rhs.e01; op_x1 = r_acc.e01; op_y1 = rhs.e11;
            end
            ENT_10: begin
                op_x0 = r_acc.e10; op_y0 = rhs.e00; op_x1 = r_acc.e11; op_y1 = rhs.e10;
            end
            default: begin
                op_x0 = r_acc.e10; op_y0 = rhs.e01; op_x1 = r_acc.e11; op_y1 = rhs.e11;
            end
        endcase
    end

    mpm_mulred #(
        .MOD_BITS (MOD_BITS),
        .RED_STEP (RED_STEP)
    ) u_mulred (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mr_start),
        .i_x0      (op_x0),
        .i_y0      (op_y0),
        .i_x1      (op_x1),
        .i_y1      (op_y1),
        .i_modulus (r_mod),
        .o_done    (mr_done),
        .o_result  (mr_result)
    );

    // Sequence squares and base multiplies, hold the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_ent       <= ENT_00;
            r_mul_base  <= 1'b0;
        end else begin
            if (out_load) begin
                r_out       <= r_acc;
                r_out_valid <= 1'b1;
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_xfer) begin
                        r_base.e00 <= i_req.a00;
                        r_base.e01 <= i_req.a01;
                        r_base.e10 <= i_req.a10;
                        r_base.e11 <= i_req.a11;
                        // Identity; the first square reduces it modulo m
                        r_acc.e00  <= MOD_BITS'(1);
                        r_acc.e01  <= '0;
                        r_acc.e10  <= '0;
                        r_acc.e11  <= MOD_BITS'(1);
                        // Zero modulus stands for 2^MOD_BITS
                        r_mod      <= (i_req.modulus == '0) ? {1'b1, {MOD_BITS{1'b0}}}
                                                            : {1'b0, i_req.modulus};
                        r_exp      <= i_req.exponent;
                        r_bit      <= BIT_W'(EXP_BITS - 1);
                        r_mul_base <= 1'b0;
                        r_ent      <= ENT_00;
                        r_state    <= ST_ISSUE;
                    end
                end
                ST_ISSUE: begin
                    r_state <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (mr_done) begin
                        case (r_ent)
                            ENT_00:  r_res.e00 <= mr_result;
                            ENT_01:  r_res.e01 <= mr_result;
                            ENT_10:  r_res.e10 <= mr_result;
                            default: r_res.e11 <= mr_result;
                        endcase
                        r_ent   <= r_ent + 2'd1;
                        r_state <= (r_ent == ENT_11) ? ST_STEP : ST_ISSUE;
                    end
                end
                ST_STEP: begin
                    r_acc <= r_res;
                    if (!r_mul_base && r_exp[r_bit]) begin
                        r_mul_base <= 1'b1;
                        r_state    <= ST_ISSUE;
                    end else begin
                        r_mul_base <= 1'b0;
                        if (r_bit == '0) begin
                            r_state <= ST_OUT;
                        end else begin
                            r_bit   <= r_bit - BIT_W'(1);
                            r_state <= ST_ISSUE;
                        end
                    end
                end
                ST_OUT: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready = (r_state == ST_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.r00   = r_out.e00;
    assign o_rsp.r01   = r_out.e01;
    assign o_rsp.r10   = r_out.e10;
    assign o_rsp.r11   = r_out.e11;

    // The shared unit only reports back while an entry is awaited
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mr_done |-> (r_state == ST_WAIT))
        else $error("multiply-reduce done outside of wait state");

    // A base multiply only follows a set exponent bit
    a_mul_on_set_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_STEP && r_mul_base) |-> r_exp[r_bit])
        else $error("base multiply on a clear exponent bit");

    // A new result is fully reduced below the modulus
    a_result_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |->
            ({1'b0, r_out.e00} < r_mod) && ({1'b0, r_out.e01} < r_mod) &&
            ({1'b0, r_out.e10} < r_mod) && ({1'b0, r_out.e11} < r_mod))
        else $error("result entry not reduced below modulus");

    // A result appears only when the sequencer finishes an item
    a_result_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_OUT))
        else $error("result loaded outside of output state");

endmodule

/* hdl/mpm_mulred.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpm_mulred: shared multiply and modular reduce unit
// Computes (x0*y0 + x1*y1) mod m with one multiplier used twice and a
// restoring remainder loop that retires RED_STEP dividend bits per cycle.
// ----------------------------------------------------------------------------
module mpm_mulred #(
    parameter int MOD_BITS = mpm_pkg::MOD_BITS,
    parameter int RED_STEP = mpm_pkg::RED_STEP
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [MOD_BITS-1:0] i_x0,
    input  logic [MOD_BITS-1:0] i_y0,
    input  logic [MOD_BITS-1:0] i_x1,
    input  logic [MOD_BITS-1:0] i_y1,
    input  logic [MOD_BITS:0]   i_modulus,
    output logic                o_done,
    output logic [MOD_BITS-1:0] o_result
);
    import mpm_pkg::*;

    localparam int PROD_W  = 2 * MOD_BITS;
    localparam int SUM_W   = PROD_W + 1;
    localparam int RED_CYC = (SUM_W + RED_STEP - 1) / RED_STEP;
    localparam int PAD_W   = RED_CYC * RED_STEP;
    localparam int CNT_W   = (RED_CYC > 1) ? $clog2(RED_CYC) : 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_ADD,
        ST_RED,
        ST_DONE
    } t_state;

    t_state              r_state;
    logic [MOD_BITS-1:0] r_x0, r_y0, r_x1, r_y1;
    logic [PROD_W-1:0]   r_prod;
    logic [SUM_W-1:0]    r_sum;
    logic [PAD_W-1:0]    r_div;
    logic [MOD_BITS-1:0] r_rem;
    logic [CNT_W-1:0]    r_cnt;
    logic [MOD_BITS-1:0] n_rem;
    logic [MOD_BITS-1:0] mul_a;
    logic [MOD_BITS-1:0] mul_b;
    logic [PROD_W-1:0]   mul_p;

    // Feed the single multiplier with the first pair, then the second
    assign mul_a = (r_state == ST_MUL0) ? r_x0 : r_x1;
    assign mul_b = (r_state == ST_MUL0) ? r_y0 : r_y1;
    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Retire RED_STEP dividend bits: shift in, compare, subtract
    always_comb begin
        logic [MOD_BITS:0] t;
        n_rem = r_rem;
        for (int s = 0; s < RED_STEP; s++) begin
            t = {n_rem, r_div[PAD_W-1-s]};
            if (t >= i_modulus) begin
                t = t - i_modulus;
            end
            n_rem = t[MOD_BITS-1:0];
        end
    end

    // Sequence the two products, the add and the remainder loop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_x0    <= i_x0;
                        r_y0    <= i_y0;
                        r_x1    <= i_x1;
                        r_y1    <= i_y1;
                        r_state <= ST_MUL0;
                    end
                end
                ST_MUL0: begin
                    r_prod  <= mul_p;
                    r_state <= ST_MUL1;
                end
                ST_MUL1: begin
                    r_sum   <= SUM_W'(r_prod);
                    r_prod  <= mul_p;
                    r_state <= ST_ADD;
                end
                ST_ADD: begin
                    r_div   <= PAD_W'(r_sum + SUM_W'(r_prod));
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= ST_RED;
                end
                ST_RED: begin
                    r_rem <= n_rem;
                    r_div <= r_div << RED_STEP;
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(RED_CYC - 1)) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_done   = (r_state == ST_DONE);
    assign o_result = r_rem;

endmodule
